FILE: hdl/fpll_pkg.sv
// Package: types and constants for the fractional-N PLL register calculator.
`default_nettype none
package fpll_pkg;

    // Datapath operation commands
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,
        OP_DIV1    = 4'd2,
        OP_DIV2    = 4'd3,
        OP_DIV3    = 4'd4,
        OP_DIV4    = 4'd5,
        OP_GCD     = 4'd6,
        OP_RED1    = 4'd7,
        OP_RED2    = 4'd8,
        OP_FINISH  = 4'd9,
        OP_STEP    = 4'd10
    } t_op;

    typedef struct packed {
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic gcd_done;
        logic fpfd_zero;
    } t_status;

    localparam int DIV_W = 32;

endpackage
`default_nettype wire

FILE: hdl/fpll_datapath.sv
// Datapath: shared restoring divider, Euclid GCD and result packing.
`default_nettype none
module fpll_datapath
    import fpll_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    input  wire logic [12:0] i_target,
    input  wire logic [7:0]  i_ref,
    input  wire logic [9:0]  i_rcnt,
    input  wire logic        i_dbl,
    input  wire logic        i_div2,
    input  wire logic [9:0]  i_spacing,
    output logic [15:0]      o_int_value,
    output logic [11:0]      o_frac_value,
    output logic [11:0]      o_mod_value,
    output logic [2:0]       o_divider_select,
    output logic             o_error_flag
);

    // divider state
    logic [DIV_W-1:0] r_num, r_den, r_quo, r_rem;
    logic [5:0]       r_cnt;
    logic             r_busy;
    // operands
    logic [12:0] r_fpfd;
    logic [2:0]  r_sel;
    logic [20:0] r_vco;
    logic [19:0] r_ival;
    logic [12:0] r_irem;
    logic [20:0] r_mval;
    logic [20:0] r_fval;
    logic [20:0] r_ga, r_gb;
    logic        r_err;

    logic [DIV_W:0]   w_trial;
    logic [DIV_W-1:0] w_rem_sh;
    logic [2:0]       w_sel;

    always_comb begin
        w_rem_sh = {r_rem[DIV_W-2:0], r_num[DIV_W-1]};
        w_trial  = {1'b0, w_rem_sh} - {1'b0, r_den};
    end

    // divider select ladder
    always_comb begin
        priority if (i_target < 13'd69)   w_sel = 3'd6;
        else if (i_target < 13'd138)      w_sel = 3'd5;
        else if (i_target < 13'd275)      w_sel = 3'd4;
        else if (i_target < 13'd550)      w_sel = 3'd3;
        else if (i_target < 13'd1100)     w_sel = 3'd2;
        else if (i_target < 13'd2200)     w_sel = 3'd1;
        else                              w_sel = 3'd0;
    end

    assign o_status.div_done  = !r_busy;
    assign o_status.gcd_done  = (r_gb == '0) && !r_busy;
    assign o_status.fpfd_zero = (r_fpfd == '0);

    // empty function for commands that do nothing
    function automatic void nop();
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (r_busy) begin
                r_num <= {r_num[DIV_W-2:0], 1'b0};
                if (!w_trial[DIV_W]) begin
                    r_rem <= w_trial[DIV_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh;
                    r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) r_busy <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_sel <= w_sel;
                    r_vco <= 21'(i_target) << w_sel;
                    r_err <= 1'b0;
                    r_num <= 32'({i_ref, 1'b0}) >> (i_dbl ? 0 : 1);
                    r_den <= 32'({1'b0, i_rcnt}) << i_div2;
                    r_rem <= '0; r_quo <= '0;
                    r_cnt <= 6'd32; r_busy <= 1'b1;
                    r_ival <= '0; r_mval <= '0; r_fval <= '0;
                end
                OP_DIV1: begin
                    // fpfd known; compute vco / fpfd
                    r_fpfd <= 13'((r_den == '0) ? 32'd0 : r_quo);
                    r_num <= 32'(r_vco);
                    r_den <= (r_den == '0) ? 32'd1 : r_quo;
                    r_rem <= '0; r_quo <= '0;
                    r_cnt <= 6'd32; r_busy <= 1'b1;
                end
                OP_DIV2: begin
                    r_ival <= 20'(r_quo);
                    r_irem <= 13'(r_rem);
                    // MOD = (2000*fpfd + sp) / (2*sp)
                    r_num <= 32'(r_fpfd) * 32'd2000 + 32'(i_spacing);
                    r_den <= {21'd0, i_spacing, 1'b0};
                    r_rem <= '0; r_quo <= '0;
                    r_cnt <= 6'd32; r_busy <= 1'b1;
                end
                OP_DIV3: begin
                    r_mval <= (i_spacing == '0) ? 21'd0 : 21'(r_quo);
                    r_num <= 32'(((i_spacing == '0) ? 32'd0 : r_quo) * {r_irem, 1'b0})
                             + 32'(r_fpfd);
                    r_den <= {18'd0, r_fpfd, 1'b0};
                    r_rem <= '0; r_quo <= '0;
                    r_cnt <= 6'd32; r_busy <= 1'b1;
                end
                OP_DIV4: begin
                    r_fval <= 21'(r_quo);
                    r_ga <= r_mval; r_gb <= 21'(r_quo);
                end
                OP_GCD: begin
                    // one Euclid step via divider
                    r_num <= 32'(r_ga); r_den <= 32'(r_gb);
                    r_rem <= '0; r_quo <= '0;
                    r_cnt <= 6'd32; r_busy <= 1'b1;
                end
                OP_STEP: begin
                    r_ga <= r_gb; r_gb <= 21'(r_rem);
                end
                OP_RED1: begin
                    // a zero GCD leaves both values as they are
                    r_num <= 32'(r_fval);
                    r_den <= (r_ga == '0) ? 32'd1 : 32'(r_ga);
                    r_rem <= '0; r_quo <= '0;
                    r_cnt <= 6'd32; r_busy <= 1'b1;
                end
                OP_RED2: begin
                    r_fval <= 21'(r_quo);
                    r_num <= 32'(r_mval);
                    r_den <= (r_ga == '0) ? 32'd1 : 32'(r_ga);
                    r_rem <= '0; r_quo <= '0;
                    r_cnt <= 6'd32; r_busy <= 1'b1;
                end
                OP_FINISH: begin
                    if (r_fpfd == '0) begin
                        r_err <= 1'b1;
                        r_ival <= '0; r_fval <= '0; r_mval <= '0;
                    end else begin
                        r_mval <= (r_quo == 32'd1) ? 21'd2 : 21'(r_quo);
                        if (r_quo == '0 || r_quo > 32'd4095 || r_ival > 20'd65535)
                            r_err <= 1'b1;
                    end
                end
                default: nop();
            endcase
        end
    end

    assign o_int_value      = r_ival[15:0];
    assign o_frac_value     = r_fval[11:0];
    assign o_mod_value      = r_mval[11:0];
    assign o_divider_select = r_sel;
    assign o_error_flag     = r_err;

endmodule
`default_nettype wire

FILE: hdl/fpll_ctrl.sv
// Controller: sequences the divisions and GCD steps of one request.
`default_nettype none
module fpll_ctrl
    import fpll_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_cmd         o_cmd,
    input  wire t_status i_status
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_D0   = 11'b00000000010,
        S_D1   = 11'b00000000100,
        S_D2   = 11'b00000001000,
        S_D3   = 11'b00000010000,
        S_GCHK = 11'b00000100000,
        S_GW   = 11'b00001000000,
        S_R1   = 11'b00010000000,
        S_R2   = 11'b00100000000,
        S_FIN  = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_wait, n_wait;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // next state and command
    always_comb begin
        n_state  = r_state;
        n_wait   = 1'b0;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.op = OP_LOAD; n_state = S_D0;
            end
            S_D0: if (i_status.div_done) begin
                o_cmd.op = OP_DIV1; n_state = S_D1;
            end
            S_D1: if (i_status.div_done) begin
                if (i_status.fpfd_zero) n_state = S_FIN;
                else begin o_cmd.op = OP_DIV2; n_state = S_D2; end
            end
            S_D2: if (i_status.div_done) begin
                o_cmd.op = OP_DIV3; n_state = S_D3;
            end
            S_D3: if (i_status.div_done) begin
                o_cmd.op = OP_DIV4; n_state = S_GCHK;
            end
            S_GCHK: if (i_status.gcd_done) n_state = S_R1;
            else begin o_cmd.op = OP_GCD; n_state = S_GW; end
            S_GW: if (i_status.div_done) begin
                o_cmd.op = OP_STEP; n_state = S_GCHK;
            end
            S_R1: begin
                o_cmd.op = OP_RED1; n_state = S_R2;
            end
            S_R2: if (i_status.div_done) begin
                if (!r_wait) begin o_cmd.op = OP_RED2; n_wait = 1'b1; end
                else n_state = S_FIN;
            end else n_wait = r_wait;
            S_FIN: begin
                o_cmd.op = OP_FINISH; n_state = S_OUT;
            end
            S_OUT: if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/frac_n_pll_register_calc.sv
// Top level: fractional-N PLL register calculator.
// Usage:
//  - Configuration: write i_cfg_we with i_cfg_index (0 ref MHz, 1 R counter,
//    2 doubler, 3 div2, 4 spacing kHz) and i_cfg_data while idle.
//  - Input: request i_target_freq_mhz with i_in_valid; o_in_stall is high
//    while a request is in work or its result waits.
//  - Output: o_out_valid with INT, FRAC, MOD, divider select, six register
//    words and an error flag; held while i_out_stall is high.
//  - Timing: all divisions share one 32-step restoring divider and run one
//    after another. Two divisions run when fPFD is zero, otherwise six plus
//    one per Euclid step: at most about 17 steps for a 12-bit MOD, about 27
//    when MOD is out of range.
//  - Flow: one request at a time; the next one is accepted only after the
//    result has left and the block is back in idle.
//  - Reset: synchronous, active low; returns configuration to defaults
//    (25 MHz, R 1, no doubler, no div2, 100 kHz) and drops any request.
`default_nettype none
module frac_n_pll_register_calc
    import fpll_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [12:0] i_target_freq_mhz,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_int_value,
    output logic [11:0]      o_frac_value,
    output logic [11:0]      o_mod_value,
    output logic [2:0]       o_divider_select,
    output logic [31:0]      o_word0,
    output logic [31:0]      o_word1,
    output logic [31:0]      o_word2,
    output logic [31:0]      o_word3,
    output logic [31:0]      o_word4,
    output logic [31:0]      o_word5,
    output logic             o_error_flag
);

    localparam logic [2:0] CFG_REF = 3'd0, CFG_R = 3'd1, CFG_DBL = 3'd2,
                           CFG_DIV2 = 3'd3, CFG_SP = 3'd4;

    logic [7:0]  r_ref;
    logic [9:0]  r_rcnt, r_sp;
    logic        r_dbl, r_div2;
    logic [12:0] r_target;
    t_cmd        w_cmd;
    t_status     w_status;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= 8'd25; r_rcnt <= 10'd1; r_dbl <= 1'b0;
            r_div2 <= 1'b0; r_sp <= 10'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REF:  r_ref  <= i_cfg_data[7:0];
                CFG_R:    r_rcnt <= i_cfg_data;
                CFG_DBL:  r_dbl  <= i_cfg_data[0];
                CFG_DIV2: r_div2 <= i_cfg_data[0];
                CFG_SP:   r_sp   <= i_cfg_data;
                default:  r_sp   <= r_sp;
            endcase
        end
    end

    // capture the request
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) r_target <= i_target_freq_mhz;
    end

    fpll_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
        .o_cmd(w_cmd), .i_status(w_status)
    );

    fpll_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_target(i_in_valid && !o_in_stall ? i_target_freq_mhz : r_target),
        .i_ref(r_ref), .i_rcnt(r_rcnt), .i_dbl(r_dbl), .i_div2(r_div2),
        .i_spacing(r_sp), .o_int_value, .o_frac_value, .o_mod_value,
        .o_divider_select, .o_error_flag
    );

    // pack register words
    assign o_word0 = {1'b0, o_int_value, o_frac_value, 3'd0};
    assign o_word1 = {17'd0, o_mod_value, 3'd1};
    assign o_word2 = {6'd0, r_dbl, r_div2, r_rcnt, 5'd15, 1'b1, 1'b0, 1'b1, 3'd0, 3'd2};
    assign o_word3 = 32'd3 | (32'd150 << 3);
    assign o_word4 = 32'd4 | (32'd3 << 3) | (32'd1 << 5) | (32'd200 << 12)
                   | (32'(o_divider_select) << 20) | (32'd1 << 23);
    assign o_word5 = 32'd5 | (32'd3 << 19) | (32'd3 << 22);

endmodule
`default_nettype wire
